[sv/kdtf_pkg.sv]
package kdtf_pkg;

  localparam int BYTE_W      = 32;
  localparam int KIB_BITS    = 22;
  localparam int NUM_DIGITS  = 7;
  localparam int DIG_W       = 4;
  localparam int BCD_W       = NUM_DIGITS * DIG_W;
  localparam int STEP_W      = $clog2(KIB_BITS);
  localparam int IDX_W       = $clog2(NUM_DIGITS);
  localparam int CHAR_W      = 7;
  localparam int LEN_W       = 4;
  localparam int COL_W       = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_K       = 7'd75;
  localparam logic [COL_W-1:0]  SCREEN_RESET = 8'd80;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [BCD_W-1:0] bcd;
  } conv_t;

endpackage

[sv/kdtf_dabble.sv]
module kdtf_dabble (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [kdtf_pkg::KIB_BITS-1:0] kib_i,
  output kdtf_pkg::conv_t               conv_o
);
  import kdtf_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [STEP_W-1:0]   step_q;
  logic [KIB_BITS-1:0] kib_q;
  logic [BCD_W-1:0]    bcd_q;
  logic [BCD_W-1:0]    bcd_adj;
  logic                last_step;

  always_comb begin
    bcd_adj = bcd_q;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_q[d*DIG_W +: DIG_W] > 4'd4) begin
        bcd_adj[d*DIG_W +: DIG_W] = bcd_q[d*DIG_W +: DIG_W] + 4'd3;
      end
    end
  end

  assign last_step = (step_q == STEP_W'(KIB_BITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      kib_q <= kib_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bcd_q <= {bcd_adj[BCD_W-2:0], kib_q[KIB_BITS-1]};
      kib_q <= {kib_q[KIB_BITS-2:0], 1'b0};
    end
  end

  assign conv_o.busy = busy_q;
  assign conv_o.done = done_q;
  assign conv_o.bcd  = bcd_q;

endmodule

[sv/kdtf_emit.sv]
module kdtf_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kdtf_pkg::conv_t             conv_i,
  input  logic [kdtf_pkg::COL_W-1:0]  disp_cols_i,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [kdtf_pkg::CHAR_W-1:0] char_code_o,
  output logic [kdtf_pkg::LEN_W-1:0]  text_length_o,
  output logic [kdtf_pkg::COL_W-1:0]  start_column_o,
  output logic                        is_last_o
);
  import kdtf_pkg::*;

  logic              busy_q;
  logic [BCD_W-1:0]  bcd_q;
  logic [IDX_W-1:0]  skip_q;
  logic [LEN_W-1:0]  chars_q;
  logic [LEN_W-1:0]  len_q;
  logic [COL_W-1:0]  col_q;
  logic              out_valid_q;
  logic [CHAR_W-1:0] char_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [COL_W-1:0]  out_col_q;
  logic              last_q;

  logic [IDX_W-1:0]  first_idx;
  logic [LEN_W-1:0]  len_d;
  logic [COL_W-1:0]  col_d;
  logic              slot_free;
  logic              emit;
  logic              emit_k;

  always_comb begin
    first_idx = '0;
    for (int d = 1; d < NUM_DIGITS; d++) begin
      if (conv_i.bcd[d*DIG_W +: DIG_W] != '0) begin
        first_idx = IDX_W'(d);
      end
    end
  end

  assign len_d     = LEN_W'(first_idx) + LEN_W'(2);
  assign col_d     = disp_cols_i - COL_W'(len_d) - COL_W'(2);
  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = busy_q && (skip_q == '0) && slot_free;
  assign emit_k    = (chars_q == LEN_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (conv_i.done) begin
        busy_q <= 1'b1;
      end else if (emit && emit_k) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (conv_i.done) begin
      bcd_q   <= conv_i.bcd;
      skip_q  <= IDX_W'(NUM_DIGITS - 1) - first_idx;
      chars_q <= len_d;
      len_q   <= len_d;
      col_q   <= col_d;
    end else if (busy_q && (skip_q != '0)) begin
      bcd_q  <= {bcd_q[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
      skip_q <= skip_q - IDX_W'(1);
    end else if (emit) begin
      bcd_q   <= {bcd_q[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
      chars_q <= chars_q - LEN_W'(1);
    end
    if (emit) begin
      char_q    <= emit_k ? CHAR_K
                          : CHAR_ZERO + CHAR_W'(bcd_q[BCD_W-1 -: DIG_W]);
      out_len_q <= len_q;
      out_col_q <= col_q;
      last_q    <= emit_k;
    end
  end

  assign busy_o         = busy_q;
  assign out_valid_o    = out_valid_q;
  assign char_code_o    = char_q;
  assign text_length_o  = out_len_q;
  assign start_column_o = out_col_q;
  assign is_last_o      = last_q;

endmodule

[sv/kib_decimal_text_formatter_top.sv]
// Formats a byte count as right-aligned KiB text: bits 31..10 of byte_count are
// converted to decimal one bit per cycle by a shift-and-add-3 converter, then
// the characters leave one per beat, most significant digit first with leading
// zeros dropped, closed by 'K' with is_last set. Every beat carries the string
// length and the start column display width - length - 2 (modulo 256). One
// item is in flight at a time: after an input beat the converter runs, its
// result passes through a done register to the character stage, which shifts
// past the leading zeros and then emits the characters; the next input beat
// is taken only after the 'K' is emitted, so output stalls before the 'K'
// delay it. The display width resets to 80; write it while idle.
module kib_decimal_text_formatter_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kdtf_pkg::COL_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kdtf_pkg::BYTE_W-1:0] byte_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [kdtf_pkg::CHAR_W-1:0] char_code_o,
  output logic [kdtf_pkg::LEN_W-1:0]  text_length_o,
  output logic [kdtf_pkg::COL_W-1:0]  start_column_o,
  output logic                        is_last_o
);
  import kdtf_pkg::*;

  logic [COL_W-1:0] disp_cols_q;
  conv_t            conv;
  logic             emit_busy;
  logic             start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_cols_q <= SCREEN_RESET;
    end else if (cfg_we_i) begin
      disp_cols_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = !conv.busy && !conv.done && !emit_busy;
  assign start      = in_valid_i && in_ready_o;

  kdtf_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kib_i   (byte_count_i[BYTE_W-1 -: KIB_BITS]),
    .conv_o  (conv)
  );

  kdtf_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .conv_i         (conv),
    .disp_cols_i    (disp_cols_q),
    .busy_o         (emit_busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .char_code_o    (char_code_o),
    .text_length_o  (text_length_o),
    .start_column_o (start_column_o),
    .is_last_o      (is_last_o)
  );

endmodule

[bench/kib_decimal_text_formatter_top_tb.sv]
module kib_decimal_text_formatter_top_tb;
  import kdtf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic [LEN_W-1:0]  text_length;
    logic [COL_W-1:0]  start_column;
    logic              is_last;
  } char_beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [COL_W-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [BYTE_W-1:0]   byte_count_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [CHAR_W-1:0]   char_code_o;
  logic [LEN_W-1:0]    text_length_o;
  logic [COL_W-1:0]    start_column_o;
  logic                is_last_o;

  logic [BYTE_W-1:0]   pending_counts[$];
  char_beat_t          expected_text[$];
  logic [COL_W-1:0]    disp_cols_q = SCREEN_RESET;
  char_beat_t          head_beat;
  int unsigned         mismatches = 0;
  int unsigned         cycle_count = 0;
  int unsigned         send_gap = 0;
  int unsigned         recv_stall = 0;
  bit                  steady_flow = 1'b0;

  kib_decimal_text_formatter_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_count_i   (byte_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .char_code_o    (char_code_o),
    .text_length_o  (text_length_o),
    .start_column_o (start_column_o),
    .is_last_o      (is_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [BCD_W-1:0] kib_to_bcd(logic [BYTE_W-1:0] bytes);
    logic [KIB_BITS-1:0] kib;
    logic [BCD_W-1:0]    bcd;
    kib = bytes[BYTE_W-1 -: KIB_BITS];
    bcd = '0;
    for (int n = 0; n < KIB_BITS; n++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd[d*DIG_W +: DIG_W] > 4'd4) bcd[d*DIG_W +: DIG_W] += 4'd3;
      end
      bcd = {bcd[BCD_W-2:0], kib[KIB_BITS-1-n]};
    end
    return bcd;
  endfunction

  task automatic predict_text(input logic [BYTE_W-1:0] bytes);
    logic [BCD_W-1:0] bcd;
    int               top_digit;
    logic [LEN_W-1:0] len;
    logic [COL_W-1:0] col;
    char_beat_t       beat;
    bcd = kib_to_bcd(bytes);
    top_digit = NUM_DIGITS - 1;
    while (top_digit > 0 && bcd[top_digit*DIG_W +: DIG_W] == '0) top_digit--;
    len = LEN_W'(top_digit + 2);
    col = disp_cols_q - COL_W'(len) - COL_W'(2);
    for (int i = top_digit; i >= 0; i--) begin
      beat.char_code    = CHAR_ZERO + CHAR_W'(bcd[i*DIG_W +: DIG_W]);
      beat.text_length  = len;
      beat.start_column = col;
      beat.is_last      = 1'b0;
      expected_text.push_back(beat);
    end
    beat.char_code    = CHAR_K;
    beat.text_length  = len;
    beat.start_column = col;
    beat.is_last      = 1'b1;
    expected_text.push_back(beat);
  endtask

  // Place a KiB value in bits 31..10 with random low bits.
  function automatic logic [BYTE_W-1:0] bytes_of_kib(int unsigned kib);
    logic [9:0] low;
    low = 10'($urandom);
    return {KIB_BITS'(kib), low};
  endfunction

  function automatic logic [BYTE_W-1:0] random_count();
    int unsigned r;
    int unsigned digits;
    int unsigned span;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom;
    digits = $urandom_range(1, 7);
    span = 1;
    for (int i = 0; i < digits; i++) span *= 10;
    if (span > (1 << KIB_BITS)) span = 1 << KIB_BITS;
    return bytes_of_kib($urandom_range(0, span - 1));
  endfunction

  task automatic write_disp_cols(input logic [COL_W-1:0] w);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    disp_cols_q = w;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_counts.size() != 0 || in_valid_i || expected_text.size() != 0);
  endtask

  // Input driver
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (pending_counts.size() != 0) begin
        in_valid_i   <= 1'b1;
        byte_count_i <= pending_counts.pop_front();
        send_gap     <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (recv_stall != 0) begin
        out_ready_i <= 1'b0;
        recv_stall  <= recv_stall - 1;
      end else begin
        out_ready_i <= 1'b1;
        recv_stall  <= pick_gap();
      end
    end
  end

  // Monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_text(byte_count_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_text.size() == 0) begin
          $error("unexpected beat: char_code %0d", char_code_o);
          mismatches++;
        end else begin
          head_beat = expected_text.pop_front();
          if (char_code_o !== head_beat.char_code) begin
            $error("char_code: expected %0d, got %0d", head_beat.char_code, char_code_o);
            mismatches++;
          end
          if (text_length_o !== head_beat.text_length) begin
            $error("text_length: expected %0d, got %0d", head_beat.text_length,
                   text_length_o);
            mismatches++;
          end
          if (start_column_o !== head_beat.start_column) begin
            $error("start_column: expected %0d, got %0d", head_beat.start_column,
                   start_column_o);
            mismatches++;
          end
          if (is_last_o !== head_beat.is_last) begin
            $error("is_last: expected %0d, got %0d", head_beat.is_last, is_last_o);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [COL_W-1:0] widths[5];
    int unsigned      p10;
    widths[0] = 8'd10;
    widths[1] = 8'd255;
    widths[2] = 8'd4;
    widths[3] = COL_W'($urandom_range(10, 255));
    widths[4] = COL_W'($urandom_range(10, 40));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero, digit-count boundaries, full scale, default width
    pending_counts.push_back(32'h0000_0000);
    pending_counts.push_back(32'h0000_03FF);
    pending_counts.push_back(32'h0000_0400);
    pending_counts.push_back(32'hFFFF_FFFF);
    pending_counts.push_back(32'hFFFF_FC00);
    pending_counts.push_back(32'hAAAA_AAAA);
    pending_counts.push_back(32'h5555_5555);
    p10 = 10;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      pending_counts.push_back(bytes_of_kib(p10 - 1));
      pending_counts.push_back(bytes_of_kib(p10));
      p10 *= 10;
    end
    pending_counts.push_back(bytes_of_kib(4_194_302));
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      write_disp_cols(widths[ph]);
      @(negedge clk_i);
      steady_flow = (ph == 1);
      if (ph == 2) begin
        // Narrow screen: the longest string wraps the column, the shortest starts at column 0
        pending_counts.push_back(32'hFFFF_FFFF);
        pending_counts.push_back(32'h0000_0000);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) pending_counts.push_back(random_count());
      wait_drained();
    end
    steady_flow = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[kib_decimal_text_formatter_top.f]
sv/kdtf_pkg.sv
sv/kdtf_dabble.sv
sv/kdtf_emit.sv
sv/kib_decimal_text_formatter_top.sv
bench/kib_decimal_text_formatter_top_tb.sv
